/* hdl/pivot_swaps_to_permutation_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the pivot-swap to permutation block.
// Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef PIVOT_SWAPS_TO_PERMUTATION_MACROS_SVH
`define PIVOT_SWAPS_TO_PERMUTATION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSP_ASSERT_IMPLY(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("psp: same-cycle check failed");
`define PSP_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("psp: next-cycle check failed");
`else
`define PSP_ASSERT_IMPLY(name, clk, rst_n, cond, prop)
`define PSP_ASSERT_NEXT(name, clk, rst_n, cond, prop)
`endif
`endif

/* hdl/psp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psp_pkg
// Shared widths and types of the pivot-swap to permutation block.
// ---------------------------------------------------------------------------
package psp_pkg;

	localparam int PIVOT_W = 11;	// 1-based pivot word
	localparam int POS_W   = 10;	// position / destination words
	localparam int EPOCH_W = 8;	// vector tag kept with each pending-table entry

	typedef logic [PIVOT_W-1:0] pivot_t;
	typedef logic [POS_W-1:0]   pos_t;

endpackage

/* hdl/psp_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psp_queue
// Two-entry FIFO between the classify front and the table back end.
// ---------------------------------------------------------------------------
module psp_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  logic [DW-1:0] push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output logic [DW-1:0] pop_data
);

	logic [DW-1:0] slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hdl/psp_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psp_front
// Accepts pivot words, checks range and vector length, assigns the row
// index and hands the classified word to the queue.
// ---------------------------------------------------------------------------
module psp_front #(
	parameter int MAX_ROWS = 1024,
	parameter int IW       = 10,
	parameter int CW       = 11
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  psp_pkg::pivot_t pivot,
	input  logic            last,
	output logic            item_valid,
	input  logic            item_ready,
	output logic [CW-1:0]   item_row,
	output logic [IW-1:0]   item_target,
	output logic            item_err,
	output logic            item_last
);

	localparam int CMPW = (CW > psp_pkg::PIVOT_W) ? CW : psp_pkg::PIVOT_W;

	logic [CW-1:0]   row_q;
	logic [CMPW-1:0] piv_ext;
	logic [CMPW-1:0] piv_m1;
	logic            accept;

	assign piv_ext = CMPW'(pivot);
	assign piv_m1  = piv_ext - CMPW'(1);

	assign in_ready    = item_ready;
	assign item_valid  = in_valid;
	assign item_row    = row_q;
	assign item_target = IW'(piv_m1);
	assign item_last   = last;
	assign item_err    = (pivot == '0) || (piv_ext > CMPW'(MAX_ROWS)) ||
	                     (row_q >= CW'(MAX_ROWS));
	assign accept      = in_valid && item_ready;

	// row index of the next word; a last word restarts it even on error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (accept) begin
			if (last) begin
				row_q <= '0;
			end else if (!item_err) begin
				row_q <= row_q + CW'(1);
			end
		end
	end

endmodule

/* hdl/psp_back.sv */
`timescale 1ns / 1ps
`include "pivot_swaps_to_permutation_macros.svh"
// ---------------------------------------------------------------------------
// psp_back
// Permutation table: reads both entries on pop, swaps or copies with
// forwarding from the previous write, and registers the result word.
// ---------------------------------------------------------------------------
module psp_back #(
	parameter int MAX_ROWS = 1024,
	parameter int IW       = 10,
	parameter int CW       = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  logic [CW-1:0] q_row,
	input  logic [IW-1:0] q_target,
	input  logic          q_err,
	input  logic          q_last,
	output logic          out_valid,
	input  logic          out_ready,
	output psp_pkg::pos_t position,
	output psp_pkg::pos_t destination,
	output logic          is_last,
	output logic          error
);

	localparam int EW = psp_pkg::EPOCH_W;
	localparam int PW = psp_pkg::POS_W;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} back_state_t;

	// Entries not yet final (index >= row) live in the tagged pending table;
	// entry i moves to the final table when its word completes.
	logic [EW+IW-1:0] p_mem [MAX_ROWS];
	logic [IW-1:0]    f_mem [MAX_ROWS];

	back_state_t   st_q;
	logic [IW-1:0] clr_addr_q;
	logic [EW-1:0] epoch_q;

	logic             s1_valid_q;
	logic [CW-1:0]    row_s1;
	logic [IW-1:0]    tgt_s1;
	logic             err_s1;
	logic             last_s1;
	logic [EW-1:0]    ep_s1;
	logic [EW+IW-1:0] p_rd_i_s1;
	logic [EW+IW-1:0] p_rd_t_s1;
	logic [IW-1:0]    f_rd_s1;

	logic          fwd_p_valid_q;
	logic [IW-1:0] fwd_p_addr_q;
	logic [IW-1:0] fwd_p_data_q;
	logic          fwd_f_valid_q;
	logic [IW-1:0] fwd_f_addr_q;
	logic [IW-1:0] fwd_f_data_q;

	logic    out_valid_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] dest_q;
	logic    last_q;
	logic    err_q;

	logic          s1_move;
	logic          pop;
	logic [IW-1:0] row_idx;
	logic [IW-1:0] vi;
	logic [IW-1:0] vt;
	logic          f_we;
	logic          p_we;

	assign s1_move = s1_valid_q && (!out_valid_q || out_ready);
	assign q_ready = (st_q == ST_RUN) && (!s1_valid_q || s1_move);
	assign pop     = q_valid && q_ready;
	assign row_idx = IW'(row_s1);
	assign f_we    = s1_move && !err_s1;
	assign p_we    = f_we && (tgt_s1 > row_idx);

	always_comb begin
		if (fwd_p_valid_q && (fwd_p_addr_q == row_idx)) begin
			vi = fwd_p_data_q;
		end else if (p_rd_i_s1[EW+IW-1:IW] == ep_s1) begin
			vi = p_rd_i_s1[IW-1:0];
		end else begin
			vi = row_idx;
		end

		priority if (tgt_s1 < row_idx) begin
			vt = (fwd_f_valid_q && (fwd_f_addr_q == tgt_s1)) ? fwd_f_data_q : f_rd_s1;
		end else if (tgt_s1 == row_idx) begin
			vt = vi;
		end else if (fwd_p_valid_q && (fwd_p_addr_q == tgt_s1)) begin
			vt = fwd_p_data_q;
		end else if (p_rd_t_s1[EW+IW-1:IW] == ep_s1) begin
			vt = p_rd_t_s1[IW-1:0];
		end else begin
			vt = tgt_s1;
		end
	end

	// table memories; reads on pop see the old word, forwarding covers it
	always_ff @(posedge clk) begin
		if (st_q == ST_CLEAR) begin
			p_mem[clr_addr_q] <= '0;
		end else if (p_we) begin
			p_mem[tgt_s1] <= {ep_s1, vi};
		end
		if (f_we) begin
			f_mem[row_idx] <= vt;
		end
		if (pop) begin
			p_rd_i_s1 <= p_mem[IW'(q_row)];
			p_rd_t_s1 <= p_mem[q_target];
			f_rd_s1   <= f_mem[q_target];
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (pop) begin
			row_s1  <= q_row;
			tgt_s1  <= q_target;
			err_s1  <= q_err;
			last_s1 <= q_last;
			ep_s1   <= epoch_q;
		end
	end

	// forwarding words: the newest write to each table
	always_ff @(posedge clk) begin
		if (f_we) begin
			fwd_f_addr_q <= row_idx;
			fwd_f_data_q <= vt;
		end
		if (p_we) begin
			fwd_p_addr_q <= tgt_s1;
			fwd_p_data_q <= vi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_f_valid_q <= 1'b0;
			fwd_p_valid_q <= 1'b0;
		end else if (s1_move) begin
			if (last_s1) begin
				fwd_f_valid_q <= 1'b0;
				fwd_p_valid_q <= 1'b0;
			end else begin
				if (f_we) begin
					fwd_f_valid_q <= 1'b1;
				end
				if (p_we) begin
					fwd_p_valid_q <= 1'b1;
				end
			end
		end
	end

	// sequencer: clear sweep, run, drain before the tag wraps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			clr_addr_q <= '0;
			epoch_q    <= EW'(1);
			s1_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLEAR: begin
					if (clr_addr_q == IW'(MAX_ROWS - 1)) begin
						st_q    <= ST_RUN;
						epoch_q <= EW'(1);
					end else begin
						clr_addr_q <= clr_addr_q + IW'(1);
					end
				end
				ST_RUN: begin
					if (pop && q_last) begin
						epoch_q <= epoch_q + EW'(1);
						if (epoch_q == '1) begin
							st_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!s1_valid_q || s1_move) begin
						st_q       <= ST_CLEAR;
						clr_addr_q <= '0;
					end
				end
				default: st_q <= ST_CLEAR;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (s1_move) begin
			pos_q  <= PW'(row_s1);
			dest_q <= err_s1 ? '0 : PW'(vt);
			last_q <= last_s1;
			err_q  <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign position    = pos_q;
	assign destination = dest_q;
	assign is_last     = last_q;
	assign error       = err_q;

	`PSP_ASSERT_IMPLY(a_pop_only_in_run, clk, arst_n, pop, st_q == ST_RUN)
	`PSP_ASSERT_IMPLY(a_err_no_write, clk, arst_n, s1_move && err_s1, !f_we && !p_we)
	`PSP_ASSERT_IMPLY(a_pend_write_ahead, clk, arst_n, p_we, tgt_s1 > row_idx)
	`PSP_ASSERT_IMPLY(a_clear_s1_empty, clk, arst_n, st_q == ST_CLEAR, !s1_valid_q)
	`PSP_ASSERT_NEXT(a_wrap_drains, clk, arst_n, pop && q_last && (epoch_q == '1), st_q == ST_DRAIN)

endmodule

/* hdl/pivot_swaps_to_permutation.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pivot_swaps_to_permutation
// Turns a 1-based pivot vector into row destinations, one word per pivot.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): pivot, last. Output channel
// (out_valid/out_ready): position, destination, is_last, error.
// Every input word gives exactly one output word, in order.
// Each accepted word is registered in the queue, then in the stage-1 table
// read registers on pop, then in the output register. Throughput is one word
// per cycle while the receiver is ready and no tag sweep runs, set by the
// single read-modify-write of the table per word; a write to an entry read
// by the next word is forwarded.
// After reset the table tags are swept, one entry per cycle; the queue takes
// two words, then in_ready stays low until the sweep ends. The same sweep runs
// after every 255th vector, once the word in flight has left the table stage.
// A stalled receiver holds the output register; the two-entry queue then
// fills and in_ready drops. Bad pivots or words past MAX_ROWS set error
// and leave the table unchanged; last still ends the vector.
// ---------------------------------------------------------------------------
module pivot_swaps_to_permutation #(
	parameter int MAX_ROWS = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  psp_pkg::pivot_t pivot,
	input  logic            last,
	output logic            out_valid,
	input  logic            out_ready,
	output psp_pkg::pos_t   position,
	output psp_pkg::pos_t   destination,
	output logic            is_last,
	output logic            error
);

	localparam int IW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int DW = CW + IW + 2;

	logic          fr_valid;
	logic          fr_ready;
	logic [CW-1:0] fr_row;
	logic [IW-1:0] fr_target;
	logic          fr_err;
	logic          fr_last;
	logic          bk_valid;
	logic          bk_ready;
	logic [DW-1:0] bk_data;

	psp_front #(
		.MAX_ROWS (MAX_ROWS),
		.IW       (IW),
		.CW       (CW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pivot       (pivot),
		.last        (last),
		.item_valid  (fr_valid),
		.item_ready  (fr_ready),
		.item_row    (fr_row),
		.item_target (fr_target),
		.item_err    (fr_err),
		.item_last   (fr_last)
	);

	psp_queue #(
		.DW (DW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  ({fr_last, fr_err, fr_target, fr_row}),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_data)
	);

	psp_back #(
		.MAX_ROWS (MAX_ROWS),
		.IW       (IW),
		.CW       (CW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (bk_valid),
		.q_ready     (bk_ready),
		.q_row       (bk_data[CW-1:0]),
		.q_target    (bk_data[CW+IW-1:CW]),
		.q_err       (bk_data[CW+IW]),
		.q_last      (bk_data[CW+IW+1]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.position    (position),
		.destination (destination),
		.is_last     (is_last),
		.error       (error)
	);

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pivot-swap to permutation block. Pivot vectors
// go in one word at a time, and each output word is checked field by field
// against a local copy of the permutation table. Directed corners come first:
// bad pivots, the last flag on a bad word, and a pivot past the vector end.
// Random vectors follow: mostly short and well formed, one that runs past
// MAX_ROWS, and enough of them to wrap the table's vector tags. Source and
// sink idle at different rates from phase to phase.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int unsigned ROWS           = 1024;
	localparam int unsigned RANDOM_WORDS   = 1800;
	localparam int unsigned MIN_VECTORS    = 270;	// enough to wrap the vector tags
	localparam int unsigned LONG_VEC_AT    = 30;
	localparam int unsigned PHASE_LEN      = 150;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES  = 12;

	typedef enum logic [1:0] {
		PH_STEADY,
		PH_SLOW_SOURCE,
		PH_SLOW_SINK,
		PH_BOTH_SLOW
	} phase_t;

	typedef struct {
		psp_pkg::pivot_t pivot;
		logic            last;
		phase_t          phase;
		bit              drain_first;
		bit              hold_sink;
	} pivot_word_t;

	typedef struct packed {
		psp_pkg::pos_t position;
		psp_pkg::pos_t destination;
		logic          is_last;
		logic          error;
	} perm_word_t;

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	logic            in_ready;
	psp_pkg::pivot_t pivot     = '0;
	logic            last      = 1'b0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	psp_pkg::pos_t   position;
	psp_pkg::pos_t   destination;
	logic            is_last;
	logic            error;

	// local copy of the permutation table
	psp_pkg::pos_t perm_map [ROWS];
	bit            map_written [ROWS];
	int unsigned   next_row;

	pivot_word_t pending_words [$];
	perm_word_t  expected_destinations [$];

	int unsigned gen_row;
	int unsigned n_queued;
	int unsigned n_vectors_queued;
	int unsigned n_sent;
	int unsigned n_bad_sent;
	int unsigned n_vectors_sent;
	int unsigned n_checked;
	int unsigned fail_count;
	int unsigned hold_requests;
	int unsigned quiet_cycles;
	phase_t      cur_phase = PH_STEADY;

	pivot_swaps_to_permutation #(
		.MAX_ROWS(ROWS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pivot      (pivot),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.position   (position),
		.destination(destination),
		.is_last    (is_last),
		.error      (error)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned idle_pct(input phase_t ph, input bit sink_side);
		case (ph)
			PH_SLOW_SOURCE: return sink_side ? 0 : 82;
			PH_SLOW_SINK:   return sink_side ? 82 : 0;
			PH_BOTH_SLOW:   return 20;
			default:        return 0;
		endcase
	endfunction

	// Table update for one pivot word; returns the word the block must emit.
	function automatic perm_word_t predict_destination(input psp_pkg::pivot_t pv,
		input logic lst);
		perm_word_t    w;
		int unsigned   row;
		int unsigned   tgt;
		psp_pkg::pos_t v_row;
		psp_pkg::pos_t v_tgt;
		row = next_row;
		w = '0;
		w.position = psp_pkg::pos_t'(row);
		w.is_last = lst;
		w.error = (pv == 0) || (int'(pv) > ROWS) || (row >= ROWS);
		if (!w.error) begin
			tgt = int'(pv) - 1;
			v_row = map_written[row] ? perm_map[row] : psp_pkg::pos_t'(row);
			v_tgt = map_written[tgt] ? perm_map[tgt] : psp_pkg::pos_t'(tgt);
			if (tgt > row) begin
				perm_map[tgt] = v_row;
				map_written[tgt] = 1'b1;
			end
			perm_map[row] = v_tgt;
			map_written[row] = 1'b1;
			w.destination = v_tgt;
			next_row = row + 1;
		end
		if (lst) begin
			foreach (map_written[k])
				map_written[k] = 1'b0;
			next_row = 0;
		end
		return w;
	endfunction

	task automatic queue_word(input int unsigned pv, input bit lst);
		pivot_word_t w;
		w.pivot = psp_pkg::pivot_t'(pv);
		w.last = lst;
		w.phase = phase_t'((n_queued / PHASE_LEN) % 4);
		w.drain_first = (n_queued != 0) && (n_queued % PHASE_LEN == 0);
		w.hold_sink = (w.phase == PH_STEADY) && (n_queued % PHASE_LEN == PHASE_LEN / 2);
		pending_words.push_back(w);
		n_queued++;
		if (pv >= 1 && pv <= ROWS && gen_row < ROWS)
			gen_row++;
		if (lst) begin
			gen_row = 0;
			n_vectors_queued++;
		end
	endtask

	// Mostly well-formed pivots near the current row so swaps collide often.
	function automatic int unsigned pick_pivot();
		int unsigned r;
		int unsigned self_pv;
		r = $urandom_range(0, 99);
		self_pv = gen_row + 1;
		if (gen_row >= ROWS)
			return $urandom_range(1, ROWS);
		if (r < 45)
			return (self_pv + $urandom_range(0, 7) > ROWS) ? ROWS : self_pv + $urandom_range(0, 7);
		if (r < 65)
			return $urandom_range(self_pv, ROWS);
		if (r < 80)
			return $urandom_range(1, self_pv);
		if (r < 88)
			return $urandom_range(0, 1) ? 1 : ROWS;
		if (r < 93)
			return 0;
		return $urandom_range(ROWS + 1, 2047);
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 50)
			$display("mismatch at output word %0d: %s", n_checked, msg);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		pivot_word_t w;
		perm_word_t  p;
		bit          slot_free;
		bit          launch;
		if (!arst_n) begin
			in_valid <= 1'b0;
			pivot <= '0;
			last <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				p = predict_destination(pivot, last);
				expected_destinations.push_back(p);
				n_sent++;
				if (p.error)
					n_bad_sent++;
				if (last)
					n_vectors_sent++;
			end
			slot_free = !in_valid || in_ready;
			launch = 1'b0;
			if (slot_free && pending_words.size() != 0)
				if (!(pending_words[0].drain_first && expected_destinations.size() != 0)
				    && $urandom_range(0, 99) >= idle_pct(pending_words[0].phase, 1'b0))
					launch = 1'b1;
			if (launch) begin
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				pivot <= w.pivot;
				last <= w.last;
				cur_phase <= w.phase;
				if (w.hold_sink)
					hold_requests <= hold_requests + 1;
			end else if (slot_free) begin
				in_valid <= 1'b0;
			end
		end
	end

	// sink: random stalls plus the occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		int unsigned hold_seen;
		int unsigned hold_left;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
		end else if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = $urandom_range(40, 80);
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= idle_pct(cur_phase, 1'b1));
		end
	end

	// monitor
	always @(posedge clk) begin
		perm_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_destinations.size() == 0) begin
				report_mismatch($sformatf("unexpected word, position %0d destination %0d",
					position, destination));
			end else begin
				want = expected_destinations.pop_front();
				if (position !== want.position)
					report_mismatch($sformatf("position %0d, want %0d", position,
						want.position));
				if (destination !== want.destination)
					report_mismatch($sformatf("destination %0d, want %0d (position %0d)",
						destination, want.destination, want.position));
				if (is_last !== want.is_last)
					report_mismatch($sformatf("is_last %0b, want %0b", is_last,
						want.is_last));
				if (error !== want.error)
					report_mismatch($sformatf("error %0b, want %0b (position %0d)", error,
						want.error, want.position));
			end
			n_checked++;
		end
	end

	// watchdog: no handshake on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned vec;
		int unsigned len;
		int unsigned r;
		int unsigned n_directed;
		foreach (map_written[k])
			map_written[k] = 1'b0;
		next_row = 0;

		// single self-swap vector
		queue_word(1, 1'b1);
		// top swap, bad pivots, copies from lower rows, swap back to the top
		queue_word(ROWS, 1'b0);
		queue_word(0, 1'b0);
		queue_word(2047, 1'b0);
		queue_word(ROWS + 1, 1'b0);
		queue_word(1, 1'b0);
		queue_word(2, 1'b0);
		queue_word(ROWS, 1'b0);
		queue_word(3, 1'b1);
		// last on a bad word still ends the vector
		queue_word(0, 1'b1);
		queue_word(5, 1'b0);
		queue_word(0, 1'b1);
		queue_word(1, 1'b1);
		// pivot past where the vector ends
		queue_word(10, 1'b0);
		queue_word(1, 1'b0);
		queue_word(3, 1'b1);
		queue_word(ROWS, 1'b1);
		queue_word(2, 1'b0);
		queue_word(1, 1'b1);
		n_directed = n_queued;

		vec = 0;
		while (n_queued < n_directed + RANDOM_WORDS || n_vectors_queued < MIN_VECTORS) begin
			if (vec == LONG_VEC_AT) begin
				// fill every row, then run past the end of the table
				while (gen_row < ROWS)
					queue_word(pick_pivot(), 1'b0);
				repeat (2) queue_word(pick_pivot(), 1'b0);
				queue_word(pick_pivot(), 1'b1);
			end else begin
				r = $urandom_range(0, 99);
				len = (r < 75) ? $urandom_range(1, 2) :
				      (r < 95) ? $urandom_range(3, 10) : $urandom_range(11, 40);
				for (int unsigned k = 1; k <= len; k++)
					queue_word(pick_pivot(), k == len);
			end
			vec++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent != n_queued)
			@(posedge clk);
		while (expected_destinations.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("checked %0d destination words over %0d vectors, %0d of them flagged bad",
			n_checked, n_vectors_sent, n_bad_sent);
		$display("phases: free running, slow source, slow sink, both slow; sink hold-offs %0d",
			hold_requests);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("FAIL");
		end
		$finish;
	end

endmodule
